>>> rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// LEB128 varint decoder package
// Status codes, field widths and encoding constants shared by the decoder.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned MAX_BYTES  = 10;
  localparam int unsigned LAST_INDEX = 9;

  localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7f;
  localparam logic [BYTE_W-1:0] CONT_BIT     = 8'h80;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_INVALID  = 2'd2;
  localparam status_t ST_END      = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    status_t            status;
  } result_t;

endpackage

>>> rtl/leb128_varint_decoder.sv
// ----------------------------------------------------------------------------
// LEB128 varint decoder
// Decodes strict 64-bit unsigned LEB128 with optional zigzag, one byte a beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one encoded byte per beat in in_tdata, with
//   in_tuser[0] selecting zigzag decode (taken from the final byte) and
//   in_tuser[1] marking end of stream (byte ignored). A result beat carries
//   the decoded value in out_tdata and the status in out_tuser
//   (0 success, 1 overflow, 2 invalid encoding, 3 end of stream).
//   Throughput is one byte per cycle while in_tready is high; the accumulate, checks and zigzag all
//   fit between the state registers and the output register.
//   Unless the receiver stalls, a value's result is registered directly in the output register.
//   When the receiver stalls, a one-entry skid buffer behind the output
//   register keeps in_tready high until both hold a result; bytes that
//   complete no value are taken as long as in_tready is high.
//   Reset clears the accumulator, byte count and sticky status and empties
//   the output side. After an error or end-of-stream result all further beats are dropped
//   until the next reset.
// ----------------------------------------------------------------------------
module leb128_varint_decoder
  import leb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic [1:0]          in_tuser,   // [0] is_signed, [1] stream_end
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [VALUE_W-1:0]  out_tdata,  // [63:0] value_bits
  output logic [STATUS_W-1:0] out_tuser   // [1:0] status
);

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  status_t            sticky_r, sticky_nxt;

  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_r, skid_nxt;

  logic               in_acc;
  logic [BYTE_W-1:0]  b;
  logic               is_signed;
  logic               stream_end;
  logic [6:0]         sh_amt;
  logic [VALUE_W-1:0] acc_or;
  logic [COUNT_W:0]   cnt_inc;
  logic               res_valid;
  result_t            res;

  assign in_tready  = !skid_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign is_signed  = in_tuser[0];
  assign stream_end = in_tuser[1];

  assign sh_amt  = 7'(cnt_r) * 7'(GROUP_BITS);
  assign acc_or  = acc_r | (VALUE_W'(b & PAYLOAD_MASK) << sh_amt);
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;

  // Decode one byte into the next state and an optional result.
  always_comb begin
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    sticky_nxt     = sticky_r;
    res_valid      = 1'b0;
    res.value_bits = '0;
    res.status     = ST_OK;
    if (in_acc && sticky_r == ST_OK) begin
      priority if (stream_end) begin
        if (cnt_r != '0) begin
          res_valid = 1'b1;
          res.status = ST_END;
        end
      end else if (cnt_r >= COUNT_W'(LAST_INDEX)
                   && (cnt_r > COUNT_W'(LAST_INDEX) || b > 8'd1)) begin
        res_valid = 1'b1;
        res.status = ST_OVERFLOW;
      end else if ((b & CONT_BIT) != '0) begin
        acc_nxt = acc_or;
        cnt_nxt = cnt_inc[COUNT_W-1:0];
        if (cnt_inc >= (COUNT_W+1)'(MAX_BYTES)) begin
          res_valid = 1'b1;
          res.status = ST_OVERFLOW;
        end
      end else if (cnt_r != '0 && b == '0) begin
        res_valid = 1'b1;
        res.status = ST_INVALID;
      end else begin
        res_valid = 1'b1;
        res.value_bits = is_signed ? ((acc_or >> 1) ^ {VALUE_W{acc_or[0]}}) : acc_or;
      end
      if (res_valid) begin
        acc_nxt    = '0;
        cnt_nxt    = '0;
        sticky_nxt = res.status;
      end
    end
  end

  // Output register with a skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_nxt       = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      cnt_r        <= '0;
      sticky_r     <= ST_OK;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      sticky_r     <= sticky_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.value_bits;
  assign out_tuser  = out_r.status;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_W'(LAST_INDEX))
    else $error("byte count beyond last index");

  a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r != ST_OK |=> sticky_r == $past(sticky_r) && cnt_r == '0)
    else $error("sticky status changed after an error");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.value_bits == '0)
    else $error("error result carries nonzero value");
`endif

endmodule
